>>> rtl/aws_pkg.sv
// ============================================================================
// aws_pkg
// Shared sizes, codes and beat types for the asymmetric waveshaper stage.
// ============================================================================
package aws_pkg;

    // Sample word and default fraction width (Q3.20 at the default sizes)
    localparam int SAMPLE_BITS    = 24;
    localparam int FRACTION_BITS  = 20;
    localparam int CFG_INDEX_BITS = 2;

    // Shaping modes held in the stage_mode register
    typedef enum logic [1:0] {
        MODE_BYPASS = 2'd0,
        MODE_CLIP   = 2'd1,
        MODE_GAIN   = 2'd2,
        MODE_OFFSET = 2'd3
    } aws_mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STAGE_MODE = 2'd0,
        REG_PARAM_A    = 2'd1,
        REG_PARAM_B    = 2'd2
    } aws_reg_t;

    // Input beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_in_block;
    } aws_in_t;

    // Output beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          was_saturated;
        logic                          last_out;
    } aws_out_t;

endpackage

>>> rtl/asymmetric_waveshaper_stage.sv
// ============================================================================
// asymmetric_waveshaper_stage
// Per-sample audio nonlinearity in signed fixed point: bypass, asymmetric
// cubic soft clip, asymmetric gain, or DC offset with make-up gain and clip.
// ============================================================================
// One sample enters per clock while the make-up divider is idle, through a
// seven-stage pipeline with at most one multiplier per stage; a stalled output holds
// the pipeline back only as far as bubbles cannot absorb it. Writing param_a
// below 1.0 starts the make-up gain divider, a radix-2 restoring divider;
// while it runs, cfg_ready is low and in_stall is high. Reset needs no clearing pass.
module asymmetric_waveshaper_stage
    import aws_pkg::*;
#(
    parameter int FRACTION_BITS = aws_pkg::FRACTION_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  aws_in_t                           in_data,
    // Sample output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output aws_out_t                          out_data,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [SAMPLE_BITS-1:0]            cfg_data
);

    // ------------------------------------------------------------------------
    // Derived sizes and constants
    // ------------------------------------------------------------------------
    localparam int SB      = SAMPLE_BITS;
    localparam int F       = FRACTION_BITS;
    localparam int NS      = 7;
    localparam int OP_W    = SB + 1;
    localparam int P_W     = 2 * OP_W;
    localparam int V_W     = F + 2;
    localparam int C_W     = ((F > SB) ? F : SB) + 1;
    localparam int PC_W    = C_W + V_W;
    localparam int DEN_W   = ((F > SB - 1) ? F : SB - 1) + 2;
    localparam int Q_W     = 2 * F + 1;
    localparam int CNT_W   = $clog2(2 * F + 2);

    localparam longint ONE_L = 64'sd1 <<< F;
    localparam longint K33_L = (33 * ONE_L + 50) / 100;
    localparam longint K10_L = (ONE_L + 5) / 10;
    localparam longint SMAX_L = (64'sd1 <<< (SB - 1)) - 1;

    localparam logic signed [OP_W-1:0]  K33_OP   = OP_W'(K33_L);
    localparam logic signed [OP_W-1:0]  ONE_OP   = OP_W'(64'sd1);
    localparam logic signed [C_W-1:0]   K10_C    = C_W'(K10_L);
    localparam logic signed [P_W-1:0]   ONE_P    = P_W'(ONE_L);
    localparam logic signed [P_W-1:0]   NONE_P   = -P_W'(ONE_L);
    localparam logic signed [P_W-1:0]   SMAX_P   = P_W'(SMAX_L);
    localparam logic signed [P_W-1:0]   SMIN_P   = -P_W'(SMAX_L) - P_W'(64'sd1);
    localparam logic signed [DEN_W-1:0] ONE_D    = DEN_W'(ONE_L);
    localparam logic [Q_W-1:0]          SMAX_Q   = Q_W'(SMAX_L);
    localparam logic [SB-1:0]           SMAX_S   = SB'(SMAX_L);
    localparam logic [CNT_W-1:0]        DIV_STEPS = CNT_W'(2 * F + 1);

    // ------------------------------------------------------------------------
    // Configuration registers and make-up gain divider
    // ------------------------------------------------------------------------
    aws_mode_t               stage_mode_reg;
    logic signed [SB-1:0]    param_a_reg;
    logic signed [SB-1:0]    param_b_reg;
    logic [SB-1:0]           make_up_reg;

    logic                    div_busy_reg;
    logic [CNT_W-1:0]        div_cnt_reg;
    logic [DEN_W-1:0]        div_rem_reg;
    logic [DEN_W-1:0]        div_den_reg;
    logic [Q_W-1:0]          div_quo_reg;

    logic                    cfg_take;
    logic signed [DEN_W-1:0] cfg_a_ext;
    logic                    cfg_a_ge_one;
    logic [DEN_W:0]          div_rem_sh;
    logic                    div_qbit;
    logic [DEN_W-1:0]        div_rem_next;

    assign cfg_ready    = !div_busy_reg;
    assign cfg_take     = cfg_valid && cfg_ready;
    assign cfg_a_ext    = {{(DEN_W-SB){cfg_data[SB-1]}}, cfg_data};
    assign cfg_a_ge_one = (cfg_a_ext >= ONE_D);

    // One restoring step: shift in the next dividend bit (only the top one is set)
    always_comb
    begin
        div_rem_sh   = {div_rem_reg, (div_cnt_reg == DIV_STEPS)};
        div_qbit     = (div_rem_sh >= {1'b0, div_den_reg});
        div_rem_next = div_qbit ? DEN_W'(div_rem_sh - {1'b0, div_den_reg})
                                : div_rem_sh[DEN_W-1:0];
    end

    // Hold registers; start the divider on a param_a write below 1.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_mode_reg <= MODE_BYPASS;
            param_a_reg    <= SB'(ONE_L);
            param_b_reg    <= SB'(ONE_L);
            make_up_reg    <= SMAX_S;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else if (div_busy_reg)
        begin
            if (div_cnt_reg == '0)
            begin
                // Saturate the quotient to the largest sample value
                make_up_reg  <= (div_quo_reg > SMAX_Q) ? SMAX_S : div_quo_reg[SB-1:0];
                div_busy_reg <= 1'b0;
            end
            else
            begin
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
            end
        end
        else if (cfg_take)
        begin
            unique case (cfg_index)
                REG_STAGE_MODE:
                begin
                    stage_mode_reg <= aws_mode_t'(cfg_data[1:0]);
                end
                REG_PARAM_A:
                begin
                    param_a_reg <= cfg_data;
                    if (cfg_a_ge_one)
                    begin
                        make_up_reg <= SMAX_S;
                    end
                    else
                    begin
                        div_busy_reg <= 1'b1;
                        div_cnt_reg  <= DIV_STEPS;
                    end
                end
                REG_PARAM_B:
                begin
                    param_b_reg <= cfg_data;
                end
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (!div_busy_reg && cfg_take && (cfg_index == REG_PARAM_A))
        begin
            div_den_reg <= DEN_W'(ONE_D - cfg_a_ext);
            div_rem_reg <= '0;
            div_quo_reg <= '0;
        end
        else if (div_busy_reg && (div_cnt_reg != '0))
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= {div_quo_reg[Q_W-2:0], div_qbit};
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage moves when it is empty or the next moves
    // ------------------------------------------------------------------------
    logic [NS:1] stg_vld_reg;
    logic [NS:1] stg_en;

    always_comb
    begin
        stg_en[NS] = !stg_vld_reg[NS] || !out_stall;
        for (int k = NS - 1; k >= 1; k--)
        begin
            stg_en[k] = !stg_vld_reg[k] || stg_en[k+1];
        end
    end

    assign in_stall  = !stg_en[1] || div_busy_reg;
    assign out_valid = stg_vld_reg[NS];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= '0;
        end
        else
        begin
            if (stg_en[1])
            begin
                stg_vld_reg[1] <= in_valid && !div_busy_reg;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (stg_en[k])
                begin
                    stg_vld_reg[k] <= stg_vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: capture sample, sign test, offset subtract
    // ------------------------------------------------------------------------
    logic signed [SB-1:0]   s1_x_reg;
    logic                   s1_last_reg;
    logic                   s1_pos_reg;
    aws_mode_t              s1_mode_reg;
    logic signed [OP_W-1:0] s1_d_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            s1_x_reg    <= in_data.sample_in;
            s1_last_reg <= in_data.last_in_block;
            s1_pos_reg  <= (in_data.sample_in > $signed(SB'(0)));
            s1_mode_reg <= stage_mode_reg;
            s1_d_reg    <= OP_W'({in_data.sample_in[SB-1], in_data.sample_in}
                                 - {param_a_reg[SB-1], param_a_reg});
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: shared multiplier (clip amount, gain, or make-up gain)
    // ------------------------------------------------------------------------
    logic signed [OP_W-1:0] s2_mul_a;
    logic signed [OP_W-1:0] s2_mul_b;
    logic signed [OP_W-1:0] s2_p_sel;
    logic                   s2_shift;

    logic signed [P_W-1:0]  s2_m_reg;
    logic                   s2_shift_reg;
    logic signed [SB-1:0]   s2_x_reg;
    logic                   s2_last_reg;
    aws_mode_t              s2_mode_reg;

    always_comb
    begin
        s2_p_sel = s1_pos_reg ? {param_a_reg[SB-1], param_a_reg}
                              : {param_b_reg[SB-1], param_b_reg};
        case (s1_mode_reg)
            MODE_CLIP:
            begin
                s2_mul_a = K33_OP;
                s2_mul_b = s2_p_sel;
                s2_shift = 1'b1;
            end
            MODE_OFFSET:
            begin
                s2_mul_a = s1_d_reg;
                s2_mul_b = s1_pos_reg ? {1'b0, make_up_reg} : ONE_OP;
                s2_shift = s1_pos_reg;
            end
            default:
            begin
                s2_mul_a = {s1_x_reg[SB-1], s1_x_reg};
                s2_mul_b = s2_p_sel;
                s2_shift = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            s2_m_reg     <= s2_mul_a * s2_mul_b;
            s2_shift_reg <= s2_shift;
            s2_x_reg     <= s1_x_reg;
            s2_last_reg  <= s1_last_reg;
            s2_mode_reg  <= s1_mode_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: rescale product, pick clip coefficient, clamp to +/-1.0
    // ------------------------------------------------------------------------
    logic signed [P_W-1:0] s3_r1;
    logic signed [P_W-1:0] s3_vsrc;
    logic signed [P_W-1:0] s3_vcl;

    logic signed [P_W-1:0] s3_r1_reg;
    logic signed [V_W-1:0] s3_v_reg;
    logic signed [C_W-1:0] s3_c_reg;
    logic signed [SB-1:0]  s3_x_reg;
    logic                  s3_last_reg;
    aws_mode_t             s3_mode_reg;

    always_comb
    begin
        s3_r1   = s2_shift_reg ? (s2_m_reg >>> F) : s2_m_reg;
        s3_vsrc = (s2_mode_reg == MODE_CLIP) ? {{(P_W-SB){s2_x_reg[SB-1]}}, s2_x_reg}
                                             : s3_r1;
        if (s3_vsrc > ONE_P)
        begin
            s3_vcl = ONE_P;
        end
        else if (s3_vsrc < NONE_P)
        begin
            s3_vcl = NONE_P;
        end
        else
        begin
            s3_vcl = s3_vsrc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            s3_r1_reg   <= s3_r1;
            s3_v_reg    <= s3_vcl[V_W-1:0];
            s3_c_reg    <= (s2_mode_reg == MODE_CLIP) ? s3_r1[C_W-1:0] : K10_C;
            s3_x_reg    <= s2_x_reg;
            s3_last_reg <= s2_last_reg;
            s3_mode_reg <= s2_mode_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: square
    // ------------------------------------------------------------------------
    logic signed [2*V_W-1:0] s4_sq;

    logic signed [V_W-1:0]   s4_x2_reg;
    logic signed [V_W-1:0]   s4_v_reg;
    logic signed [C_W-1:0]   s4_c_reg;
    logic signed [P_W-1:0]   s4_r1_reg;
    logic signed [SB-1:0]    s4_x_reg;
    logic                    s4_last_reg;
    aws_mode_t               s4_mode_reg;

    assign s4_sq = s3_v_reg * s3_v_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[4])
        begin
            s4_x2_reg   <= V_W'(s4_sq >>> F);
            s4_v_reg    <= s3_v_reg;
            s4_c_reg    <= s3_c_reg;
            s4_r1_reg   <= s3_r1_reg;
            s4_x_reg    <= s3_x_reg;
            s4_last_reg <= s3_last_reg;
            s4_mode_reg <= s3_mode_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: cube
    // ------------------------------------------------------------------------
    logic signed [2*V_W-1:0] s5_cu;

    logic signed [V_W-1:0]   s5_x3_reg;
    logic signed [V_W-1:0]   s5_v_reg;
    logic signed [C_W-1:0]   s5_c_reg;
    logic signed [P_W-1:0]   s5_r1_reg;
    logic signed [SB-1:0]    s5_x_reg;
    logic                    s5_last_reg;
    aws_mode_t               s5_mode_reg;

    assign s5_cu = s4_x2_reg * s4_v_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[5])
        begin
            s5_x3_reg   <= V_W'(s5_cu >>> F);
            s5_v_reg    <= s4_v_reg;
            s5_c_reg    <= s4_c_reg;
            s5_r1_reg   <= s4_r1_reg;
            s5_x_reg    <= s4_x_reg;
            s5_last_reg <= s4_last_reg;
            s5_mode_reg <= s4_mode_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: scale the cube by the clip coefficient
    // ------------------------------------------------------------------------
    logic signed [PC_W-1:0] s6_p3_reg;
    logic signed [V_W-1:0]  s6_v_reg;
    logic signed [P_W-1:0]  s6_r1_reg;
    logic signed [SB-1:0]   s6_x_reg;
    logic                   s6_last_reg;
    aws_mode_t              s6_mode_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[6])
        begin
            s6_p3_reg   <= s5_c_reg * s5_x3_reg;
            s6_v_reg    <= s5_v_reg;
            s6_r1_reg   <= s5_r1_reg;
            s6_x_reg    <= s5_x_reg;
            s6_last_reg <= s5_last_reg;
            s6_mode_reg <= s5_mode_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: final subtract, mode select, saturate to the sample range
    // ------------------------------------------------------------------------
    logic signed [PC_W-1:0] s7_sh;
    logic signed [P_W-1:0]  s7_clip;
    logic signed [P_W-1:0]  s7_y;
    aws_out_t               s7_out;
    aws_out_t               out_data_reg;

    always_comb
    begin
        s7_sh   = s6_p3_reg >>> F;
        s7_clip = P_W'({{(P_W-V_W){s6_v_reg[V_W-1]}}, s6_v_reg}
                       - {{(P_W-PC_W){s7_sh[PC_W-1]}}, s7_sh});
        case (s6_mode_reg)
            MODE_CLIP,
            MODE_OFFSET:
            begin
                s7_y = s7_clip;
            end
            MODE_GAIN:
            begin
                s7_y = s6_r1_reg;
            end
            default:
            begin
                s7_y = {{(P_W-SB){s6_x_reg[SB-1]}}, s6_x_reg};
            end
        endcase
        s7_out.last_out = s6_last_reg;
        if (s7_y > SMAX_P)
        begin
            s7_out.sample_out    = SMAX_P[SB-1:0];
            s7_out.was_saturated = 1'b1;
        end
        else if (s7_y < SMIN_P)
        begin
            s7_out.sample_out    = SMIN_P[SB-1:0];
            s7_out.was_saturated = 1'b1;
        end
        else
        begin
            s7_out.sample_out    = s7_y[SB-1:0];
            s7_out.was_saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[7])
        begin
            out_data_reg <= s7_out;
        end
    end

    assign out_data = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // No sample may enter while the make-up gain is being derived
    a_no_input_while_dividing: assert property (
        @(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> in_stall
    ) else $error("sample accepted while make-up divider busy");

    // A param_a write below 1.0 must start the divider
    a_div_starts: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == REG_PARAM_A) && !cfg_a_ge_one)
            |=> div_busy_reg
    ) else $error("make-up divider did not start");

    // The make-up gain is always a non-negative sample value
    a_make_up_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        !make_up_reg[SB-1]
    ) else $error("make-up gain out of range");

endmodule
